@@ rtl/core/rti_pkg.sv @@
package rti_pkg;
  localparam int WL_W   = 32;
  localparam int RSP_W  = 17;
  localparam int PACK_W = 3 * RSP_W;
  localparam logic [RSP_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DOMAIN = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  function automatic logic [RSP_W-1:0] sat_one(input logic [RSP_W-1:0] v);
    sat_one = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction
endpackage

@@ rtl/core/rti_if.sv @@
interface rti_in_if;
  import rti_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [5:0]       point_index;
  logic [WL_W-1:0]  wavelength_pm;
  logic [RSP_W-1:0] red_in;
  logic [RSP_W-1:0] green_in;
  logic [RSP_W-1:0] blue_in;
  modport source (output valid, operation, point_index, wavelength_pm, red_in, green_in,
                  blue_in, input ready);
  modport sink (input valid, operation, point_index, wavelength_pm, red_in, green_in,
                blue_in, output ready);
endinterface

interface rti_out_if;
  import rti_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [RSP_W-1:0] red_out;
  logic [RSP_W-1:0] green_out;
  logic [RSP_W-1:0] blue_out;
  modport source (output valid, status, red_out, green_out, blue_out, input ready);
  modport sink (input valid, status, red_out, green_out, blue_out, output ready);
endinterface

interface rti_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/rgb_response_table_interpolator.sv @@
// a write reads the lower neighbour, then offers its result; a query reads entry 0 and the last
//   entry and offers a domain status when outside the table; other queries search with probes
//   (S_PRD, S_FETW) through the registered memory read, at most ceil(log2(point_count)) of them,
//   then read entries lo and lo-1 and return entry lo as it is, or interpolate: divider start,
//   16-bit fraction divide, one multiply a channel
// throughput: one item at a time; the next beat is taken the cycle after the result beat
// reset: synchronous, active high; point_count returns to 2, tables hold no reset value
module rgb_response_table_interpolator
  import rti_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input logic clk,
  input logic rst,
  rti_in_if.sink   in_ch,
  rti_out_if.source out_ch,
  rti_cfg_if.sink  cfg
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRD   = 4'd1;  // lower neighbour read for write check
  localparam logic [3:0] S_BND0  = 4'd2;  // entry 0 read
  localparam logic [3:0] S_BNDH  = 4'd3;  // last entry read
  localparam logic [3:0] S_PROBE = 4'd4;
  localparam logic [3:0] S_PRD   = 4'd5;
  localparam logic [3:0] S_FETCH = 4'd6;  // read entry lo
  localparam logic [3:0] S_FETL  = 4'd7;  // read entry lo-1
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_FETW  = 4'd11;

  logic [3:0] state;
  logic [CW-1:0] point_count;

  // latched item
  logic [5:0]      idx;
  logic [WL_W-1:0] q;
  logic [PACK_W-1:0] wr_rsp;

  // search
  logic [AW-1:0] lo, hi, mid;
  logic [WL_W-1:0] wu, wl;
  logic [PACK_W-1:0] rsp_u, rsp_l;
  logic [15:0] frac;
  logic [1:0]  ch;
  logic [RSP_W-1:0] acc [3];

  // result register
  logic [1:0] res_status;

  // memories
  logic            wl_we, rsp_we;
  logic [AW-1:0]   raddr;
  logic [WL_W-1:0] wl_rd;
  logic [PACK_W-1:0] rsp_rd;

  rti_ram #(.WIDTH(WL_W), .DEPTH(MAX_POINTS)) u_wl_ram (
    .clk(clk), .we(wl_we), .waddr(AW'(idx)), .wdata(q), .raddr(raddr), .rdata(wl_rd)
  );
  rti_ram #(.WIDTH(PACK_W), .DEPTH(MAX_POINTS)) u_rsp_ram (
    .clk(clk), .we(rsp_we), .waddr(AW'(idx)), .wdata(wr_rsp), .raddr(raddr),
    .rdata(rsp_rd)
  );

  // divider for the fraction, started once both bracketing wavelengths are registered
  logic div_start, div_done;
  logic div_go;
  logic [15:0] div_q;
  rti_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(q - wl), .den(wu - wl),
    .done(div_done), .quo(div_q)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign out_ch.valid  = (state == S_OUT);
  assign out_ch.status = res_status;
  assign out_ch.red_out   = acc[0];
  assign out_ch.green_out = acc[1];
  assign out_ch.blue_out  = acc[2];

  assign mid = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  // one channel a cycle: a*(1-f) + b*f, floored
  logic [RSP_W-1:0] ca, cb;
  logic [16:0]      one_m_f;
  logic [34:0]      mix;
  always_comb begin
    ca = RSP_W'(rsp_l >> (RSP_W * ch));
    cb = RSP_W'(rsp_u >> (RSP_W * ch));
    one_m_f = 17'd65536 - {1'b0, frac};
    mix = 35'(ca) * 35'(one_m_f) + 35'(cb) * 35'(frac);
  end

  // read address selection, data arrives one state later
  always_comb begin
    raddr = '0;
    unique case (state)
      S_IDLE:  raddr = AW'(in_ch.point_index) - AW'(1);
      S_BNDH:  raddr = hi;
      S_PROBE: raddr = mid;
      S_FETW:  raddr = mid;
      S_FETL:  raddr = lo - AW'(1);
      default: raddr = lo;
    endcase
  end

  logic idx_ok;
  assign idx_ok = (32'(idx) < 32'(MAX_POINTS));
  logic wr_good;
  assign wr_good = idx_ok && (q != '0) && ((idx == 6'd0) || (q > wl_rd));
  assign wl_we  = (state == S_WRD) && wr_good;
  assign rsp_we = wl_we;
  assign div_start = div_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      point_count <= CW'(2);
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (cfg.valid) begin
        if (cfg.data < 7'd2) begin
          point_count <= CW'(2);
        end else if (32'(cfg.data) > 32'(MAX_POINTS)) begin
          point_count <= CW'(MAX_POINTS);
        end else begin
          point_count <= CW'(cfg.data);
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            idx <= in_ch.point_index;
            q   <= in_ch.wavelength_pm;
            wr_rsp <= {sat_one(in_ch.blue_in), sat_one(in_ch.green_in),
                       sat_one(in_ch.red_in)};
            lo <= '0;
            hi <= AW'(point_count - CW'(1));
            state <= (in_ch.operation == OP_WRITE) ? S_WRD : S_BND0;
          end
        end
        S_WRD: begin
          res_status <= wr_good ? ST_OK : ST_REJECT;
          for (int k = 0; k < 3; k++) acc[k] <= '0;
          state <= S_OUT;
        end
        S_BND0: state <= S_BNDH;
        S_BNDH: begin
          // raddr was lo (0) in S_BND0, hi now
          state <= S_PROBE;
          wl <= wl_rd;
        end
        S_PROBE: begin
          if (q < wl || q > wl_rd) begin
            res_status <= ST_DOMAIN;
            for (int k = 0; k < 3; k++) acc[k] <= '0;
            state <= S_OUT;
          end else if (lo < hi) begin
            state <= S_PRD;
          end else begin
            state <= S_FETCH;
          end
        end
        S_PRD: begin
          if (wl_rd < q) lo <= mid + AW'(1);
          else hi <= mid;
          state <= S_FETW;
        end
        S_FETW: begin
          state <= (lo < hi) ? S_PRD : S_FETCH;
        end
        S_FETCH: begin
          state <= S_FETL;
        end
        S_FETL: begin
          wu <= wl_rd;
          rsp_u <= rsp_rd;
          res_status <= ST_OK;
          state <= S_DIV;
        end
        S_DIV: begin
          if (lo == '0 || !(wl_rd < wu && wu != q && wl_rd < q && q < wu)) begin
            for (int k = 0; k < 3; k++) acc[k] <= RSP_W'(rsp_u >> (RSP_W * k));
            state <= S_OUT;
          end else begin
            wl <= wl_rd;
            rsp_l <= rsp_rd;
            div_go <= 1'b1;
            state <= S_MUL;
            ch <= 2'd3;
          end
        end
        S_MUL: begin
          if (ch == 2'd3) begin
            if (div_done) begin
              frac <= div_q;
              ch <= 2'd0;
            end
          end else begin
            acc[ch] <= RSP_W'(mix >> 16);
            if (ch == 2'd2) state <= S_OUT;
            ch <= ch + 2'd1;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> !in_ch.ready)
    else $error("input taken while a result is pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && res_status != ST_OK) |-> (acc[0] == '0 && acc[1] == '0))
    else $error("non-zero response with bad status");
  assert property (@(posedge clk) disable iff (rst) wl_we |-> (q != '0))
    else $error("zero wavelength stored");
endmodule

@@ rtl/core/rti_ram.sv @@
module rti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/rti_div.sv @@
// restoring divider: (num << 16) / den, one quotient bit per cycle
module rti_div
  import rti_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WL_W-1:0] num,
  input  logic [WL_W-1:0] den,
  output logic            done,
  output logic [15:0]     quo
);
  logic [WL_W:0]   rem;
  logic [WL_W-1:0] dvs;
  logic [4:0]      cnt;
  logic            busy;
  logic [WL_W:0]   trial;

  // numerator is below the divisor, so the remainder stays under it
  assign trial = {rem[WL_W-1:0], 1'b0} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        rem  <= {1'b0, num};
        dvs  <= den;
      end else if (busy) begin
        if (!trial[WL_W] || rem[WL_W-1]) begin
          rem <= {1'b0, trial[WL_W-1:0]};
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[WL_W-1:0], 1'b0};
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ sim/testbench.sv @@
module testbench;
  import rti_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 3000;   // cycles without any beat before giving up
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off

  typedef struct packed {
    logic             op;
    logic [5:0]       idx;
    logic [WL_W-1:0]  wl;
    logic [RSP_W-1:0] red;
    logic [RSP_W-1:0] green;
    logic [RSP_W-1:0] blue;
  } point_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [RSP_W-1:0] red;
    logic [RSP_W-1:0] green;
    logic [RSP_W-1:0] blue;
  } point_rsp_t;

  logic clk;
  logic rst;

  rti_in_if  in_ch();
  rti_out_if out_ch();
  rti_cfg_if cfg_ch();

  rgb_response_table_interpolator #(.MAX_POINTS(TABLE_DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // shadow copy of the block state, advanced on accepted beats only
  logic [WL_W-1:0]  wl_mirror [TABLE_DEPTH];
  logic [RSP_W-1:0] rsp_mirror [TABLE_DEPTH][3];
  int unsigned      count_mirror;

  // generator side view of the table, used to keep stimulus legal
  logic [WL_W-1:0]  wl_plan [TABLE_DEPTH];
  int unsigned      count_plan;

  point_req_t pending[$];
  point_rsp_t rsp_expected[$];
  point_req_t cur_req;
  bit         offering;
  bit         idle_en;
  bit         hold_off;
  int         in_gap;
  int         out_stall;
  int         mismatches;
  int         quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [RSP_W-1:0] clip_one(input logic [RSP_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // next result of the table for one accepted item, updating the shadow state
  function automatic point_rsp_t predict_response(input point_req_t r);
    point_rsp_t  res;
    int unsigned lo, hi, mid;
    logic [63:0] wl_lo, wl_hi, frac, a, b;
    res = '0;
    if (r.op == OP_WRITE) begin
      if (r.wl == 0 || (r.idx > 0 && r.wl <= wl_mirror[r.idx-1])) begin
        res.status = ST_REJECT;
      end else begin
        wl_mirror[r.idx]     = r.wl;
        rsp_mirror[r.idx][0] = clip_one(r.red);
        rsp_mirror[r.idx][1] = clip_one(r.green);
        rsp_mirror[r.idx][2] = clip_one(r.blue);
      end
      return res;
    end
    lo = 0;
    hi = count_mirror - 1;
    if (r.wl < wl_mirror[0] || r.wl > wl_mirror[hi]) begin
      res.status = ST_DOMAIN;
      return res;
    end
    // lower-bound binary search
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (wl_mirror[mid] < r.wl) lo = mid + 1;
      else hi = mid;
    end
    res.status = ST_OK;
    res.red    = rsp_mirror[lo][0];
    res.green  = rsp_mirror[lo][1];
    res.blue   = rsp_mirror[lo][2];
    // interpolate only between strictly bracketing points
    if (lo > 0 && wl_mirror[lo-1] < r.wl && r.wl < wl_mirror[lo]) begin
      wl_lo = wl_mirror[lo-1];
      wl_hi = wl_mirror[lo];
      frac  = ((64'(r.wl) - wl_lo) << 16) / (wl_hi - wl_lo);
      for (int k = 0; k < 3; k++) begin
        a = rsp_mirror[lo-1][k];
        b = rsp_mirror[lo][k];
        a = (a * (64'd65536 - frac) + b * frac) >> 16;
        case (k)
          0: res.red   = a[RSP_W-1:0];
          1: res.green = a[RSP_W-1:0];
          default: res.blue = a[RSP_W-1:0];
        endcase
      end
    end
    return res;
  endfunction

  // input driver: one beat offered at a time, random gap between beats while idle_en is set
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      in_gap   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rsp_expected = {rsp_expected, predict_response(cur_req)};
        offering = 1'b0;
      end
      if (!offering) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0) begin
          cur_req = pending.pop_front();
          in_ch.operation     <= cur_req.op;
          in_ch.point_index   <= cur_req.idx;
          in_ch.wavelength_pm <= cur_req.wl;
          in_ch.red_in        <= cur_req.red;
          in_ch.green_in      <= cur_req.green;
          in_ch.blue_in       <= cur_req.blue;
          offering = 1'b1;
          in_gap   = idle_en ? $urandom_range(0, 10) : 0;
        end
      end
      in_ch.valid <= offering;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    point_rsp_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.red_out, out_ch.green_out, out_ch.blue_out};
        if (rsp_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %0d rgb %0d %0d %0d",
                     got.status, got.red, got.green, got.blue);
        end else begin
          want = rsp_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected status %0d rgb %0d %0d %0d,",
                        " got %0d rgb %0d %0d %0d"},
                       want.status, want.red, want.green, want.blue,
                       got.status, got.red, got.green, got.blue);
          end
        end
        out_stall = idle_en ? $urandom_range(0, 10) : 0;
      end else if (out_stall > 0 && !hold_off) begin
        out_stall--;
      end
      out_ch.ready <= (out_stall == 0) && !hold_off;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    @(negedge rst);
    repeat (1500) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // watchdog on beats of any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic logic [RSP_W-1:0] rand_rsp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ONE_Q16;
      2: return RSP_W'($urandom);   // may exceed one, saturates
      default: return RSP_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic queue_write(input int idx, input logic [WL_W-1:0] wl);
    point_req_t r;
    r = '{OP_WRITE, 6'(idx), wl, rand_rsp(), rand_rsp(), rand_rsp()};
    if (wl != 0 && (idx == 0 || wl > wl_plan[idx-1])) wl_plan[idx] = wl;
    pending = {pending, r};
  endtask

  task automatic queue_eval(input logic [WL_W-1:0] q);
    point_req_t r;
    r = '{OP_EVAL, 6'($urandom), q, RSP_W'($urandom), RSP_W'($urandom), RSP_W'($urandom)};
    pending = {pending, r};
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || offering || rsp_expected.size() > 0) @(posedge clk);
  endtask

  task automatic write_count(input logic [6:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    count_mirror = (v < 2) ? 2 : (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
    count_plan   = count_mirror;
    cfg_ch.valid <= 1'b0;
  endtask

  // a random query somewhere inside the planned table
  function automatic logic [WL_W-1:0] inside_query();
    int unsigned j;
    logic [WL_W-1:0] lo_wl, hi_wl;
    j = $urandom_range(1, count_plan - 1);
    lo_wl = wl_plan[j-1];
    hi_wl = wl_plan[j];
    if (hi_wl <= lo_wl) return hi_wl;
    case ($urandom_range(0, 7))
      0: return lo_wl;
      1: return hi_wl;
      default: return lo_wl + $urandom_range(0, hi_wl - lo_wl);
    endcase
  endfunction

  initial begin
    logic [6:0]      count_set [9] = '{7'd2, 7'd0, 7'd64, 7'd127, 7'd1, 7'd33, 7'd5, 7'd65,
                                       7'd17};
    logic [WL_W-1:0] wl;
    logic [WL_W-1:0] step;
    int              idx;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.operation     = OP_WRITE;
    in_ch.point_index   = '0;
    in_ch.wavelength_pm = '0;
    in_ch.red_in        = '0;
    in_ch.green_in      = '0;
    in_ch.blue_in       = '0;
    out_ch.ready  = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    idle_en       = 1'b1;
    count_mirror  = 2;
    count_plan    = 2;
    @(negedge rst);

    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      write_count(count_set[ph]);
      idle_en = (ph % 3) != 2;

      // fill the whole table in ascending order
      case (ph % 3)
        0: wl = $urandom_range(1, 1000);
        1: wl = $urandom_range(1, 1 << 20);
        default: wl = $urandom_range(1, 1 << 30);
      endcase
      if (ph == 0) wl = 1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        case (ph % 3)
          0: step = $urandom_range(1, 3);
          1: step = $urandom_range(1, 100000);
          default: step = $urandom_range(1, 1 << 25);
        endcase
        if (i > 0) wl = wl + step;
        if (ph == 5 && i == TABLE_DEPTH - 1) wl = '1;
        queue_write(i, wl);
      end

      // edges of the domain
      queue_eval('0);
      queue_eval('1);
      queue_eval(wl_plan[0]);
      queue_eval(wl_plan[0] - 1);
      queue_eval(wl_plan[count_plan-1]);
      queue_eval(wl_plan[count_plan-1] + 1);

      // rejected writes: zero wavelength, non-ascending wavelength
      queue_write($urandom_range(0, 63), '0);
      idx = $urandom_range(1, 63);
      queue_write(idx, wl_plan[idx-1] - $urandom_range(0, 3));

      for (int n = 0; n < 110; n++) begin
        case ($urandom_range(0, 19))
          0: queue_eval($urandom);
          1: queue_eval(wl_plan[0] - $urandom_range(1, 5));
          2: queue_eval(wl_plan[count_plan-1] + $urandom_range(1, 5));
          3: begin
            idx = $urandom_range(1, 63);
            queue_write(idx, wl_plan[idx-1] - $urandom_range(0, 2));
          end
          4: begin
            // rewrite past the next entry, leaving the table out of order
            if (n > 80) begin
              idx = $urandom_range(1, 62);
              queue_write(idx, wl_plan[idx+1] + $urandom_range(0, 2));
            end else begin
              queue_eval(inside_query());
            end
          end
          default: queue_eval(inside_query());
        endcase
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && rsp_expected.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
